>>> design/crc_command_block_checker_assert.svh
// Assertion macros used by the checker file ccbc_checker.sv.
`ifndef CRC_COMMAND_BLOCK_CHECKER_ASSERT_SVH
`define CRC_COMMAND_BLOCK_CHECKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CCBC_ASSERT_NOW(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off during reset.
`define CCBC_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> design/ccbc_pkg.sv
// Types and constants for the command block checker.
package ccbc_pkg;

    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] MAX_LEN_RESET = 16'd61;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_LENGTH = 2'd0,
        PH_BODY   = 2'd1,
        PH_CHECK  = 2'd2,
        PH_DROP   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_GOOD           = 3'd0,
        ST_CORRECTED      = 3'd1,
        ST_CRC_ERROR      = 3'd2,
        ST_TOO_LONG       = 3'd3,
        ST_UNEXPECTED_END = 3'd4,
        ST_EMPTY          = 3'd5,
        ST_DONE           = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CFG_IGNORE_CRC = 2'd0,
        CFG_MAX_LEN    = 2'd1
    } cfg_index_t;

endpackage

>>> design/ccbc_crc_fold.sv
// Parallel CRC-16 update: folds one 16-bit word, MSB first, into the CRC.
module ccbc_crc_fold
(
    input  logic [15:0] crc_in,
    input  logic [15:0] word,
    output logic [15:0] crc_out
);
    import ccbc_pkg::*;

    logic [15:0] crc_work;
    logic [15:0] word_work;
    logic        top;

    always_comb
    begin
        crc_work  = crc_in;
        word_work = word;
        top       = 1'b0;
        for (int k = 0; k < 16; k++)
        begin
            top       = crc_work[15] ^ word_work[15];
            crc_work  = {crc_work[14:0], 1'b0} ^ (top ? CRC_POLY : 16'h0000);
            word_work = {word_work[14:0], 1'b0};
        end
        crc_out = crc_work;
    end

endmodule

>>> design/crc_command_block_checker.sv
// Top level of the length-prefixed command block checker with CRC-16.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------
//  input    | in_valid / in_stall         | data_word[15:0], stream_end
//  output   | out_valid / out_stall       | status[2:0], crc_value, block_count
//  config   | cfg_valid / cfg_ready       | cfg_index[1:0], cfg_data[15:0]
//
// One word per cycle while in_stall is low; a result is registered once its word fires.
// The CRC fold and the state update sit between the input register and the result register.
// While a result waits, one more word is taken into the input register, then in_stall rises.
// rst_n clears all control state and config; the word and payload registers are not reset.
// cfg_ready is always high, so every cfg_valid write is taken.
module crc_command_block_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] data_word,
    input  logic        stream_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] crc_value,
    output logic [15:0] block_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ccbc_pkg::*;

    // configuration
    logic        ignore_reg;
    logic [15:0] max_len_reg;

    // input register
    logic        in_full_reg, in_full_next;
    logic [15:0] in_word_reg;
    logic        in_end_reg;

    // stream state
    phase_t      phase_reg, phase_next;
    logic [15:0] words_left_reg, words_left_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] blocks_reg, blocks_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    status_t     status_reg, status_next;
    logic [15:0] crc_value_reg, crc_value_next;
    logic [15:0] count_reg, count_next;

    logic        in_accept;
    logic        fire;
    logic        emit;
    logic [15:0] fold_base;
    logic [15:0] fold_result;
    logic [15:0] blocks_inc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_reg  <= 1'b0;
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IGNORE_CRC: ignore_reg  <= cfg_data[0];
                CFG_MAX_LEN:    max_len_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign fire      = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && !fire;
    assign in_accept = in_valid && !in_stall;
    assign in_full_next = in_accept || (in_full_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_word_reg <= data_word;
            in_end_reg  <= stream_end;
        end
    end

    assign fold_base  = (phase_reg == PH_LENGTH) ? CRC_INIT : crc_reg;
    assign blocks_inc = (blocks_reg == COUNT_MAX) ? blocks_reg : blocks_reg + 16'd1;

    ccbc_crc_fold u_fold
    (
        .crc_in  (fold_base),
        .word    (in_word_reg),
        .crc_out (fold_result)
    );

    always_comb
    begin
        phase_next      = phase_reg;
        words_left_next = words_left_reg;
        crc_next        = crc_reg;
        blocks_next     = blocks_reg;
        emit            = 1'b0;
        status_next     = ST_GOOD;
        crc_value_next  = 16'h0000;
        count_next      = blocks_reg;

        if (in_end_reg)
        begin
            case (phase_reg)
                PH_LENGTH:
                begin
                    emit        = 1'b1;
                    status_next = (blocks_reg == 16'd0) ? ST_EMPTY : ST_DONE;
                end
                PH_BODY, PH_CHECK:
                begin
                    emit        = 1'b1;
                    status_next = ST_UNEXPECTED_END;
                end
                default: ;
            endcase
            // rearm for a new stream
            phase_next      = PH_LENGTH;
            words_left_next = 16'd0;
            crc_next        = CRC_INIT;
            blocks_next     = 16'd0;
        end
        else
        begin
            case (phase_reg)
                PH_LENGTH:
                begin
                    if (in_word_reg >= max_len_reg)
                    begin
                        phase_next  = PH_DROP;
                        emit        = 1'b1;
                        status_next = ST_TOO_LONG;
                    end
                    else
                    begin
                        crc_next        = fold_result;
                        words_left_next = in_word_reg;
                        phase_next      = (in_word_reg == 16'd0) ? PH_CHECK : PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    crc_next        = fold_result;
                    words_left_next = words_left_reg - 16'd1;
                    if (words_left_reg == 16'd1)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    emit           = 1'b1;
                    crc_value_next = crc_reg;
                    crc_next       = CRC_INIT;
                    if (in_word_reg == crc_reg || ignore_reg)
                    begin
                        status_next = (in_word_reg == crc_reg) ? ST_GOOD : ST_CORRECTED;
                        blocks_next = blocks_inc;
                        count_next  = blocks_inc;
                        phase_next  = PH_LENGTH;
                    end
                    else
                    begin
                        status_next = ST_CRC_ERROR;
                        phase_next  = PH_DROP;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LENGTH;
            words_left_reg <= 16'd0;
            crc_reg        <= CRC_INIT;
            blocks_reg     <= 16'd0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            words_left_reg <= words_left_next;
            crc_reg        <= crc_next;
            blocks_reg     <= blocks_next;
        end
    end

    always_comb
    begin
        if (fire)
        begin
            out_valid_next = emit;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // load the payload only with a new result; hold it while stalled
    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            status_reg    <= status_next;
            crc_value_reg <= crc_value_next;
            count_reg     <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign crc_value   = crc_value_reg;
    assign block_count = count_reg;

endmodule

>>> design/ccbc_checker.sv
// Port-level checks for the command block checker, bound to its top level.
`include "crc_command_block_checker_assert.svh"

module ccbc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [15:0] crc_value,
    input logic [15:0] block_count
);
    import ccbc_pkg::*;

    logic [34:0] result_payload;
    logic        no_crc_status;
    logic        counted_status;

    assign result_payload = {status, crc_value, block_count};
    assign no_crc_status  = (status == ST_TOO_LONG) || (status == ST_UNEXPECTED_END) ||
                            (status == ST_EMPTY) || (status == ST_DONE);
    assign counted_status = (status == ST_DONE) || (status == ST_GOOD) ||
                            (status == ST_CORRECTED);

    // a held result keeps its payload
    `CCBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_payload))

    // statuses without a checked block carry no CRC
    `CCBC_ASSERT_NOW(a_crc_zero, out_valid && no_crc_status, crc_value == 16'h0000)

    // an empty stream has no accepted blocks
    `CCBC_ASSERT_NOW(a_empty_count, out_valid && status == ST_EMPTY, block_count == 16'd0)

    // done and accepted blocks always carry a nonzero count
    `CCBC_ASSERT_NOW(a_done_count, out_valid && counted_status, block_count != 16'd0)

endmodule

bind crc_command_block_checker ccbc_checker u_ccbc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .crc_value   (crc_value),
    .block_count (block_count)
);
